FILE: sv/sem_pkg.sv
// Shared types and constants for the RGB Sobel edge magnitude block.
package sem_pkg;

  localparam int unsigned REG_IDX_W = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } reg_idx_t;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  localparam logic [11:0] WIDTH_RESET  = 12'd640;
  localparam logic [11:0] HEIGHT_RESET = 12'd480;

  // Above 255*256 the rounded root is at least 255.
  localparam logic [20:0] MAG_CLAMP_SUM = 21'd65280;
  localparam logic [7:0]  MAG_MAX       = 8'd255;

  typedef struct packed {
    logic       action;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_GRAD,
    ST_SQUARE,
    ST_ROOT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic shift;
    logic grad;
    logic square;
    logic root_step;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic live;
    logic emit;
    logic root_last;
    logic out_free;
  } status_t;

endpackage

FILE: sv/sobel_edge_magnitude_rgb.sv
// Top level of the streaming RGB Sobel edge magnitude block.
// Each accepted word is handled in turn. A new pixel or draining flush that
// yields a result goes through accept, line buffer update, gradients,
// squares, the bit-by-bit rounded root, then the load into the output
// register. The load waits while the output register still holds a word
// that has not been taken. Pixels that produce no result yet stop after the
// line buffer update, and an ignored flush is only accepted. The result for
// a pixel appears once the pixel one row and one column later is taken;
// after the last pixel, width+1 flush words drain the frame. A write to the
// width or height register restarts the frame.
module sobel_edge_magnitude_rgb #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sem_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sem_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data
);
  import sem_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  sem_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sem_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: sv/sem_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sem_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/sem_ctrl.sv
// Controller state machine that sequences one word through the datapath.
module sem_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sem_pkg::status_t status,
  output sem_pkg::cmd_t    cmd
);
  import sem_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && status.live) begin
          cmd.start = 1'b1;
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd.shift = 1'b1;
        state_nxt = status.emit ? ST_GRAD : ST_IDLE;
      end
      ST_GRAD: begin
        cmd.grad  = 1'b1;
        state_nxt = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command at once");
  a_start_to_shift: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> cmd.shift)
    else $error("accepted word not shifted next cycle");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> status.out_free)
    else $error("result loaded over a word not yet taken");
`endif

endmodule

FILE: sv/sem_dp.sv
// Datapath: positions, line buffer, 3x3 window, gradients and rounded root.
module sem_dp #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [11:0]          cfg_data,
  input  sem_pkg::in_word_t    in_data,
  input  sem_pkg::cmd_t        cmd,
  output sem_pkg::status_t     status,
  input  logic                 out_ready,
  output logic                 out_valid,
  output sem_pkg::out_word_t   out_data
);
  import sem_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 3);

  logic [11:0]   width_r, height_r;
  logic [CW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  logic [31:0]   w_int, h_int;

  logic [CW-1:0] in_col_r, out_col_r;
  logic [RW-1:0] in_row_r, out_row_r;

  logic [23:0]   pix_r;
  logic          emit_r;
  logic [23:0]   win_r [3][3];

  logic          frame_done, is_pixel, restart;
  logic [AW-1:0] rd_addr;
  logic [47:0]   rd_data;

  logic signed [10:0] gx_r [3];
  logic signed [10:0] gy_r [3];
  logic signed [10:0] gx_c [3];
  logic signed [10:0] gy_c [3];
  logic [20:0]        sum_r [3];
  logic [7:0]         root_r [3];
  logic [2:0]         bit_r;
  logic               last_r;
  logic               last_c;

  logic               use_r0, use_r2, use_c0, use_c2;
  logic               out_valid_r;
  out_word_t          out_data_r;

  always_comb begin
    w_int = (width_r == '0) ? 32'd1 :
            ((32'(width_r) > MAX_WIDTH) ? MAX_WIDTH : 32'(width_r));
    h_int = (height_r == '0) ? 32'd1 :
            ((32'(height_r) > MAX_HEIGHT) ? MAX_HEIGHT : 32'(height_r));
    w_eff = w_int[CW-1:0];
    h_eff = h_int[RW-1:0];
  end

  assign is_pixel   = (in_data.action == ACT_PIXEL);
  assign frame_done = (in_row_r >= h_eff);
  assign restart    = is_pixel && frame_done;
  assign rd_addr    = restart ? '0 : in_col_r[AW-1:0];

  assign status.live      = is_pixel || (frame_done && (out_row_r < h_eff));
  assign status.emit      = emit_r;
  assign status.root_last = (bit_r == 3'd0);
  assign status.out_free  = !out_valid_r || out_ready;

  // Upper row in the high half, middle row in the low half.
  sem_ram #(.WIDTH(48), .DEPTH(MAX_WIDTH)) u_lines (
    .clk     (clk),
    .we      (cmd.shift),
    .wr_addr (in_col_r[AW-1:0]),
    .wr_data ({rd_data[23:0], pix_r}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WIDTH_RESET;
      height_r  <= HEIGHT_RESET;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        width_r <= cfg_data;
      end
      if (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT) begin
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
      end
      if (cfg_index == REG_IMAGE_HEIGHT) begin
        height_r <= cfg_data;
      end
    end else begin
      if (cmd.start && restart) begin
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
      end
      if (cmd.shift) begin
        if (in_col_r + 1'b1 >= w_eff) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + 1'b1;
        end else begin
          in_col_r <= in_col_r + 1'b1;
        end
      end
      if (cmd.load) begin
        if (out_col_r + 1'b1 >= w_eff) begin
          out_col_r <= '0;
          out_row_r <= out_row_r + 1'b1;
        end else begin
          out_col_r <= out_col_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else begin
      if (cmd.start) begin
        if (is_pixel) begin
          pix_r  <= {in_data.red_in, in_data.green_in, in_data.blue_in};
          emit_r <= !frame_done && ((in_row_r >= RW'(2)) ||
                    (in_row_r == RW'(1) && in_col_r != '0));
        end else begin
          pix_r  <= '0;
          emit_r <= 1'b1;
        end
      end
      if (cmd.shift) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r][0] <= win_r[r][1];
          win_r[r][1] <= win_r[r][2];
        end
        win_r[0][2] <= rd_data[47:24];
        win_r[1][2] <= rd_data[23:0];
        win_r[2][2] <= pix_r;
      end
    end
  end

  // Neighbors outside the frame count as zero.
  always_comb begin
    use_r0 = (out_row_r != '0);
    use_r2 = ({1'b0, out_row_r} + 1'b1) < {1'b0, h_eff};
    use_c0 = (out_col_r != '0);
    use_c2 = ({1'b0, out_col_r} + 1'b1) < {1'b0, w_eff};
    last_c = (({1'b0, out_row_r} + 1'b1) == {1'b0, h_eff}) &&
             (({1'b0, out_col_r} + 1'b1) == {1'b0, w_eff});
  end

  always_comb begin
    logic signed [10:0] v [3][3];
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          v[r][c] = $signed({3'b000, win_r[r][c][8*(2-ch) +: 8]});
          if ((r == 0 && !use_r0) || (r == 2 && !use_r2) ||
              (c == 0 && !use_c0) || (c == 2 && !use_c2)) begin
            v[r][c] = '0;
          end
        end
      end
      gx_c[ch] = (v[0][2] - v[0][0]) + ((v[1][2] - v[1][0]) <<< 1) + (v[2][2] - v[2][0]);
      gy_c[ch] = (v[2][0] + (v[2][1] <<< 1) + v[2][2]) -
                 (v[0][0] + (v[0][1] <<< 1) + v[0][2]);
    end
  end

  always_ff @(posedge clk) begin
    logic signed [21:0] gxw, gyw;
    logic [7:0]         t;
    logic [15:0]        prod;
    if (cmd.grad) begin
      gx_r   <= gx_c;
      gy_r   <= gy_c;
      last_r <= last_c;
    end
    if (cmd.square) begin
      for (int ch = 0; ch < 3; ch++) begin
        gxw = 22'(gx_r[ch]);
        gyw = 22'(gy_r[ch]);
        sum_r[ch]  <= 21'(gxw * gxw) + 21'(gyw * gyw);
        root_r[ch] <= '0;
      end
      bit_r <= 3'd7;
    end
    // One result bit per cycle: keep it when t*(t-1) stays below the sum.
    if (cmd.root_step) begin
      for (int ch = 0; ch < 3; ch++) begin
        t    = root_r[ch] | (8'd1 << bit_r);
        prod = 16'(t) * 16'(t - 8'd1);
        if ({5'b0, prod} < sum_r[ch]) begin
          root_r[ch] <= t;
        end
      end
      bit_r <= bit_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r.red_out    <= (sum_r[0] > MAG_CLAMP_SUM) ? MAG_MAX : root_r[0];
      out_data_r.green_out  <= (sum_r[1] > MAG_CLAMP_SUM) ? MAG_MAX : root_r[1];
      out_data_r.blue_out   <= (sum_r[2] > MAG_CLAMP_SUM) ? MAG_MAX : root_r[2];
      out_data_r.frame_last <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_in_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_col_r < w_eff)
    else $error("input column beyond the row");
  a_out_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_col_r < w_eff)
    else $error("output column beyond the row");
  a_out_lags_in: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (out_row_r <= in_row_r))
    else $error("output position ahead of input position");
`endif

endmodule
